// ===== design/cqs_pkg.sv =====
// shared types, codes and sizes for the circular queue with search
// no dependencies

package cqs_pkg;

  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 32;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 2;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 32;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  // which result the datapath registers
  typedef enum logic [2:0] {
    RES_OK    = 3'd0,
    RES_FULL  = 3'd1,
    RES_EMPTY = 3'd2,
    RES_MISS  = 3'd3,
    RES_DEQ   = 3'd4,
    RES_HIT   = 3'd5
  } res_sel_e;

  typedef struct packed {
    logic     latch_in;    // capture op and key of the accepted beat
    logic     enq_write;   // store key at tail, advance tail
    logic     deq_pop;     // advance head
    logic     rd_head;     // read entry at head
    logic     rd_next;     // read next scan slot, advance scan
    logic     scan_start;  // scan pointer to head, count to zero
    logic     load_res;    // register a result beat
    res_sel_e res_sel;
  } cqs_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic hit;       // entry last read equals the key
    logic last;      // scan is at the newest entry
    logic out_free;  // output register can take a beat this cycle
  } cqs_sts_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
    logic [PTR_W-1:0] nxt;
    nxt = (slot == PTR_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    return nxt;
  endfunction

endpackage

// ===== design/cqs_ctrl.sv =====
// sequencer of the circular queue: one operation at a time
// depends on cqs_pkg

module cqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cqs_pkg::cqs_sts_t sts_i,
  output cqs_pkg::cqs_cmd_t cmd_o
);
  import cqs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_POP  = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = RES_OK;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_ENQ: begin
            if (sts_i.out_free) begin
              cmd_o.load_res  = 1'b1;
              cmd_o.res_sel   = sts_i.full ? RES_FULL : RES_OK;
              cmd_o.enq_write = !sts_i.full;
              state_d         = S_IDLE;
            end
          end
          OP_DEQ, OP_SRCH: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.load_res = 1'b1;
                cmd_o.res_sel  = RES_EMPTY;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.rd_head    = 1'b1;
              cmd_o.scan_start = (sts_i.op == OP_SRCH);
              state_d          = (sts_i.op == OP_SRCH) ? S_SCAN : S_POP;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.load_res = 1'b1;
              cmd_o.res_sel  = RES_OK;
              state_d        = S_IDLE;
            end
          end
        endcase
      end
      S_POP: begin
        if (sts_i.out_free) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_sel  = RES_DEQ;
          cmd_o.deq_pop  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.last) begin
          if (sts_i.out_free) begin
            cmd_o.load_res = 1'b1;
            cmd_o.res_sel  = sts_i.hit ? RES_HIT : RES_MISS;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/cqs_datapath.sv =====
// entry memory, head/tail/occupancy, scan pointer and output register
// depends on cqs_pkg

module cqs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cqs_pkg::OP_W-1:0]      op_i,
  input  logic signed [cqs_pkg::IN_W-1:0] data_in_i,
  input  cqs_pkg::cqs_cmd_t             cmd_i,
  output cqs_pkg::cqs_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cqs_pkg::STAT_W-1:0]    status_o,
  output logic signed [cqs_pkg::OUT_W-1:0] data_out_o,
  output logic [cqs_pkg::SLOT_W-1:0]    slot_index_o
);
  import cqs_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [PTR_W-1:0]      rd_addr;
  logic                  rd_en;

  op_e                   op_q;
  logic [DATA_WIDTH-1:0] key_q;
  logic [PTR_W-1:0]      head_q, tail_q, scan_q;
  logic [OCC_W-1:0]      occ_q, cnt_q;

  logic                  out_valid_q;
  logic [STAT_W-1:0]     status_q, status_d;
  logic [OUT_W-1:0]      data_q, data_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;

  logic signed [DATA_WIDTH-1:0] rd_signed;

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= op_e'(op_i);
      key_q <= DATA_WIDTH'($unsigned(data_in_i));
    end
  end

  // entry memory, one write and one registered read port
  assign rd_en   = cmd_i.rd_head | cmd_i.rd_next;
  assign rd_addr = cmd_i.rd_next ? next_slot(scan_q) : head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_write) begin
      mem_q[tail_q] <= key_q;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // queue pointers and scan position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
      scan_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.enq_write) begin
        tail_q <= next_slot(tail_q);
        occ_q  <= occ_q + 1'b1;
      end else if (cmd_i.deq_pop) begin
        head_q <= next_slot(head_q);
        occ_q  <= occ_q - 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_q <= head_q;
        cnt_q  <= '0;
      end else if (cmd_i.rd_next) begin
        scan_q <= next_slot(scan_q);
        cnt_q  <= cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.full     = (occ_q == OCC_W'(DEPTH));
  assign sts_o.empty    = (occ_q == '0);
  assign sts_o.hit      = (rd_q == key_q);
  assign sts_o.last     = ((cnt_q + 1'b1) == occ_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // result beat
  assign rd_signed = rd_q;

  always_comb begin
    status_d = ST_OK;
    data_d   = '0;
    slot_d   = '0;
    case (cmd_i.res_sel)
      RES_OK:    status_d = ST_OK;
      RES_FULL:  status_d = ST_FULL;
      RES_EMPTY: status_d = ST_EMPTY;
      RES_MISS:  status_d = ST_MISS;
      RES_DEQ:   data_d   = OUT_W'(rd_signed);
      RES_HIT:   slot_d   = SLOT_W'(scan_q);
      default:   status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      status_q <= status_d;
      data_q   <= data_d;
      slot_q   <= slot_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_out_o   = data_q;
  assign slot_index_o = slot_q;

  // tail always sits occupancy slots past head
  logic [OCC_W:0] tail_sum;
  logic [OCC_W:0] tail_wrap;
  assign tail_sum  = (OCC_W+1)'(head_q) + (OCC_W+1)'(occ_q);
  assign tail_wrap = (tail_sum >= (OCC_W+1)'(DEPTH)) ? tail_sum - (OCC_W+1)'(DEPTH) : tail_sum;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_write |-> !sts_o.full)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.deq_pop |-> !sts_o.empty)
    else $error("pop from an empty queue");

  a_ptr_consist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (OCC_W+1)'(tail_q) == tail_wrap)
    else $error("tail, head and occupancy disagree");

  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_res |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

endmodule

// ===== design/circular_queue_with_search.sv =====
// top level of the circular queue with search: controller plus datapath
// depends on cqs_pkg, cqs_ctrl, cqs_datapath
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o | op_i, data_in_i
//  out     | output    | out_valid_o/ out_ready_i| status_o, data_out_o, slot_index_o
//
// enqueue, nop and empty/full cases: the execute state registers the result on out
// dequeue: the execute state reads the head entry and the pop state registers it on out
// search: the execute state reads the head entry, then the scan state compares the entries
//   in turn up to a hit or the newest; one memory read per cycle from head toward tail
// rst_ni clears pointers, occupancy and the output valid; the entry memory is not cleared
// a new beat is accepted while a result still waits on out; the sequencer only stalls
//   when it has a result to register and the output register is still full

module circular_queue_with_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cqs_pkg::OP_W-1:0]         op_i,
  input  logic signed [cqs_pkg::IN_W-1:0]  data_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cqs_pkg::STAT_W-1:0]       status_o,
  output logic signed [cqs_pkg::OUT_W-1:0] data_out_o,
  output logic [cqs_pkg::SLOT_W-1:0]       slot_index_o
);
  import cqs_pkg::*;

  // command and status between sequencer and datapath
  cqs_cmd_t cmd;
  cqs_sts_t sts;

  // sequencer: idle, execute, pop (wait on read data), scan
  cqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, pointers, compare and the output register
  cqs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op_i),
    .data_in_i    (data_in_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .slot_index_o (slot_index_o)
  );

endmodule
